// ===== design/paf_pkg.sv =====
package paf_pkg;

    localparam int COORD_BITS = 16;
    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int CFG_BITS   = 16;
    localparam int BASE_BITS  = 8;
    localparam int SCORE_BITS = OUT_BITS + 1;
    localparam int OTHER_BITS = 4;
    localparam int LEN_SEL_BITS = 4;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    localparam logic [BASE_BITS-1:0] CH_A       = 8'h41;
    localparam logic [BASE_BITS-1:0] CH_T       = 8'h54;
    localparam logic [BASE_BITS-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BASE_BITS-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [BASE_BITS-1:0] CASE_SHIFT = 8'h20;

    localparam logic [OTHER_BITS-1:0] MAX_OTHER = 4'd10;

    // false-discovery test: 100 * (n - len + 1) <= 4^len
    localparam int MIN_RUN_LEN     = 5;
    localparam int ALWAYS_PASS_LEN = 16;
    localparam int FDR_BITS        = 2 * (ALWAYS_PASS_LEN - 1) + 1;

    typedef enum logic [1:0] {
        REG_SCAN_FOR_A   = 2'd0,
        REG_SEQ_LENGTH   = 2'd1,
        REG_RIGHT_OFFSET = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                run_found;
        logic [OUT_BITS-1:0] run_start;
        logic [OUT_BITS-1:0] run_end;
        logic                is_last;
    } t_result;

endpackage

// ===== design/paf_item_if.sv =====
interface paf_item_if import paf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BASE_BITS-1:0] base;
    logic                 final_base;

    modport source (output valid, output base, output final_base, input ready);
    modport sink   (input valid, input base, input final_base, output ready);
endinterface

// ===== design/paf_res_if.sv =====
interface paf_res_if import paf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                run_found;
    logic [OUT_BITS-1:0] run_start;
    logic [OUT_BITS-1:0] run_end;
    logic                is_last;

    modport source (output valid, output run_found, output run_start, output run_end,
                    output is_last, input ready);
    modport sink   (input valid, input run_found, input run_start, input run_end,
                    input is_last, output ready);
endinterface

// ===== design/poly_a_run_finder.sv =====
// poly-A / poly-T run finder
// i_item takes one flank base per transaction, in scan order (forward for
// poly-A, reversed for poly-T); final_base marks the last base of a flank.
// o_res carries zero or one result per base: a result for every accepted
// run, and always one for the final base (is_last = 1).
// i_cfg_* writes scan_for_a, seq_length and right_offset; write them only
// between flanks while the block is idle.
// each base is scored and tested in the cycle it is accepted; its result
// enters a two-entry output queue and shows on o_res in the next cycle when
// the queue was empty. one base per cycle sustained while results drain.
// i_item.ready drops while both entries hold results the receiver has not
// taken, so a stalled receiver blocks the input as soon as the queue fills;
// ready returns the cycle after a result is taken.
// reset (synchronous, active low) clears the scan state and the queue and
// sets scan_for_a to 1, seq_length and right_offset to 0.
module poly_a_run_finder import paf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    paf_item_if.sink              i_item,
    paf_res_if.source             o_res
);

    logic                   r_scan_for_a;
    logic [CFG_BITS-1:0]    r_seq_length;
    logic [CFG_BITS-1:0]    r_right_offset;

    logic [COORD_BITS-1:0]  r_scan_idx;
    logic [COORD_BITS-1:0]  r_cur_len;
    logic signed [SCORE_BITS-1:0] r_score;
    logic [SCORE_BITS-2:0]  r_best_score;
    logic [COORD_BITS-1:0]  r_best_len;
    logic [COORD_BITS-1:0]  r_best_pos;
    logic [OTHER_BITS-1:0]  r_other_cnt;

    t_result                r_q0;
    t_result                r_q1;
    logic [1:0]             r_cnt;

    logic                   acc;
    logic                   pop;
    logic                   push;
    logic [BASE_BITS-1:0]   b_up;
    logic [BASE_BITS-1:0]   target;
    logic [BASE_BITS-1:0]   alt;
    logic                   hit_tgt;
    logic                   hit_alt;
    logic [COORD_BITS-1:0]  n_cur_len;
    logic signed [SCORE_BITS-1:0] n_score;
    logic [OTHER_BITS-1:0]  n_other_cnt;
    logic [COORD_BITS-1:0]  pos;
    logic                   better;
    logic [SCORE_BITS-2:0]  n_best_score;
    logic [COORD_BITS-1:0]  n_best_len;
    logic [COORD_BITS-1:0]  n_best_pos;
    logic                   clear_run;
    logic                   test_run;
    logic                   found;
    logic [OUT_BITS-1:0]    pos_x;
    logic [OUT_BITS-1:0]    len_x;
    logic [OUT_BITS-1:0]    end_a;
    t_result                n_res;

    function automatic logic run_passes(input logic [COORD_BITS-1:0] len,
                                        input logic [CFG_BITS-1:0]   seq_len);
        logic [CFG_BITS:0]   avail;
        logic [CFG_BITS:0]   len_w;
        logic [CFG_BITS:0]   diff;
        logic [FDR_BITS-1:0] lhs;
        logic [FDR_BITS-1:0] rhs;
        logic                ok;
        avail = {1'b0, seq_len} + (CFG_BITS+1)'(1);
        len_w = (CFG_BITS+1)'(len);
        diff  = avail - len_w;
        // x100 as shift-add
        lhs   = (FDR_BITS'(diff) << 6) + (FDR_BITS'(diff) << 5) + (FDR_BITS'(diff) << 2);
        rhs   = FDR_BITS'(1) << {len[LEN_SEL_BITS-1:0], 1'b0};
        if (len < COORD_BITS'(MIN_RUN_LEN)) begin
            ok = 1'b0;
        end else if (len >= COORD_BITS'(ALWAYS_PASS_LEN)) begin
            ok = 1'b1;
        end else if (avail <= len_w) begin
            ok = 1'b1;
        end else begin
            ok = (lhs <= rhs);
        end
        return ok;
    endfunction

    assign acc  = i_item.valid && i_item.ready;
    assign pop  = o_res.valid && o_res.ready;

    always_comb begin
        b_up = i_item.base;
        if (i_item.base >= CH_LOWER_A && i_item.base <= CH_LOWER_Z) begin
            b_up = i_item.base - CASE_SHIFT;
        end
        target  = r_scan_for_a ? CH_A : CH_T;
        alt     = r_scan_for_a ? CH_T : CH_A;
        hit_tgt = (b_up == target);
        hit_alt = (b_up == alt);

        n_cur_len = (r_cur_len != COORD_MAX) ? r_cur_len + COORD_BITS'(1) : r_cur_len;
        if (hit_tgt) begin
            n_score     = r_score + SCORE_BITS'(1);
            n_other_cnt = r_other_cnt;
        end else begin
            n_score     = hit_alt ? r_score - SCORE_BITS'(1) : r_score - SCORE_BITS'(3);
            n_other_cnt = r_other_cnt + OTHER_BITS'(1);
        end

        if (r_scan_for_a) begin
            pos = r_scan_idx;
        end else begin
            pos = COORD_BITS'(r_seq_length) - COORD_BITS'(1) - r_scan_idx;
        end

        better       = n_score > $signed({1'b0, r_best_score});
        n_best_score = better ? n_score[SCORE_BITS-2:0] : r_best_score;
        n_best_len   = better ? n_cur_len : r_best_len;
        n_best_pos   = better ? pos : r_best_pos;

        clear_run = n_score[SCORE_BITS-1] || (n_other_cnt > MAX_OTHER);
        test_run  = clear_run || i_item.final_base;
        found     = test_run && run_passes(n_best_len, r_seq_length);

        pos_x = OUT_BITS'(n_best_pos);
        len_x = OUT_BITS'(n_best_len);
        end_a = pos_x + OUT_BITS'(r_right_offset) + OUT_BITS'(1);

        n_res.run_found = found;
        n_res.is_last   = i_item.final_base;
        n_res.run_start = '0;
        n_res.run_end   = '0;
        if (found) begin
            n_res.run_start = r_scan_for_a ? end_a - len_x : pos_x;
            n_res.run_end   = r_scan_for_a ? end_a : pos_x + len_x;
        end

        push = acc && (found || i_item.final_base);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_for_a   <= 1'b1;
            r_seq_length   <= '0;
            r_right_offset <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SCAN_FOR_A:   r_scan_for_a   <= i_cfg_wdata[0];
                REG_SEQ_LENGTH:   r_seq_length   <= i_cfg_wdata;
                REG_RIGHT_OFFSET: r_right_offset <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx   <= '0;
            r_cur_len    <= '0;
            r_score      <= '0;
            r_best_score <= '0;
            r_best_len   <= '0;
            r_best_pos   <= '0;
            r_other_cnt  <= '0;
        end else if (acc) begin
            if (test_run) begin
                r_cur_len    <= '0;
                r_score      <= '0;
                r_best_score <= '0;
                r_best_len   <= '0;
                r_other_cnt  <= '0;
            end else begin
                r_cur_len    <= n_cur_len;
                r_score      <= n_score;
                r_best_score <= n_best_score;
                r_best_len   <= n_best_len;
                r_other_cnt  <= n_other_cnt;
            end
            if (i_item.final_base) begin
                r_scan_idx <= '0;
                r_best_pos <= '0;
            end else begin
                r_best_pos <= n_best_pos;
                if (r_scan_idx != COORD_MAX) begin
                    r_scan_idx <= r_scan_idx + COORD_BITS'(1);
                end
            end
        end
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        // new transaction lands in the head when the queue is empty after the pop
        if (push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_q0 <= n_res;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
        if (push && r_cnt == 2'd1 && !pop) begin
            r_q1 <= n_res;
        end
    end

    assign i_item.ready    = (r_cnt != 2'd2);
    assign o_res.valid     = (r_cnt != 2'd0);
    assign o_res.run_found = r_q0.run_found;
    assign o_res.run_start = r_q0.run_start;
    assign o_res.run_end   = r_q0.run_end;
    assign o_res.is_last   = r_q0.is_last;

endmodule

// ===== design/paf_chk.sv =====
module paf_chk import paf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_in_final,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_out_found,
    input  logic [OUT_BITS-1:0] i_out_start,
    input  logic [OUT_BITS-1:0] i_out_end,
    input  logic                i_out_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_found)
            && $stable(i_out_start) && $stable(i_out_end) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // final base into an empty queue shows up on the next cycle
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_final && !i_out_valid |=> i_out_valid && i_out_last)
        else $error("final base gave no closing result");

    // only the closing result may carry no run
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_last && i_out_start == '0 && i_out_end == '0)
        else $error("empty result not closing the flank");

    a_full_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input blocked with nothing to deliver");

endmodule

bind poly_a_run_finder paf_chk u_paf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_final  (i_item.final_base),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_found (o_res.run_found),
    .i_out_start (o_res.run_start),
    .i_out_end   (o_res.run_end),
    .i_out_last  (o_res.is_last)
);
